// File: rtl/vn_pkg.sv
package vn_pkg;

  // pipeline depths
  localparam int unsigned DivStages  = 29;
  localparam int unsigned SqrtStages = 16;
  // input, square and sum registers, then the two units, then the output register
  localparam int unsigned Latency    = 3 + DivStages + SqrtStages + 1;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic        [15:0] length;
    logic               zero_vector;
  } out_t;

  // per-item sideband carried next to the arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] root;
  } sqrt_st_t;

  // one digit of the restoring square root: bring in two radicand bits
  function automatic sqrt_st_t sqrt_step(input logic [16:0] rem, input logic [15:0] root,
                                         input logic [1:0] pair);
    logic [18:0] rem_in;
    logic [18:0] trial;
    sqrt_st_t    res;
    rem_in = {rem, pair};
    trial  = {1'b0, root, 2'b01};
    if (rem_in >= trial) begin
      res.rem  = 17'(rem_in - trial);
      res.root = {root[14:0], 1'b1};
    end else begin
      res.rem  = rem_in[16:0];
      res.root = {root[14:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// File: rtl/vn_div.sv
module vn_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [31:0]         sum_i,
  input  logic [2:0][30:0]    sq_i,
  input  vn_pkg::side_t       side_i,
  output logic                valid_o,
  output logic [2:0][28:0]    quo_o,
  output vn_pkg::side_t       side_o
);

  logic [vn_pkg::DivStages-1:0] vld_q;
  logic [31:0]                  sum_q  [vn_pkg::DivStages];
  logic [2:0][31:0]             rem_q  [vn_pkg::DivStages];
  logic [2:0][28:0]             quo_q  [vn_pkg::DivStages];
  vn_pkg::side_t                side_q [vn_pkg::DivStages];

  // one quotient bit per stage for all three lanes, floor(sq * 2^28 / sum)
  for (genvar g = 0; g < vn_pkg::DivStages; g++) begin : g_stage
    logic [31:0]      sum_in;
    logic [2:0][32:0] rin;
    logic [2:0][28:0] qin;
    logic [2:0][31:0] rem_d;
    logic [2:0][28:0] quo_d;
    logic             vld_in;
    vn_pkg::side_t    side_in;

    if (g == 0) begin : g_first
      assign sum_in  = sum_i;
      assign vld_in  = valid_i;
      assign side_in = side_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rin[l] = {2'b00, sq_i[l]};
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign sum_in  = sum_q[g-1];
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rin[l] = {rem_q[g-1][l], 1'b0};
        assign qin[l] = quo_q[g-1][l];
      end
    end

    // trial subtract
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rin[l] >= {1'b0, sum_in}) begin
          rem_d[l] = 32'(rin[l] - {1'b0, sum_in});
          quo_d[l] = {qin[l][27:0], 1'b1};
        end else begin
          rem_d[l] = rin[l][31:0];
          quo_d[l] = {qin[l][27:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sum_q[g]  <= sum_in;
      rem_q[g]  <= rem_d;
      quo_q[g]  <= quo_d;
      side_q[g] <= side_in;
    end
  end

  assign valid_o = vld_q[vn_pkg::DivStages-1];
  assign quo_o   = quo_q[vn_pkg::DivStages-1];
  assign side_o  = side_q[vn_pkg::DivStages-1];

endmodule

// File: rtl/vn_sqrt.sv
module vn_sqrt (
  input  logic        clk_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);

  logic [31:0]       rad_q [vn_pkg::SqrtStages];
  vn_pkg::sqrt_st_t  st_q  [vn_pkg::SqrtStages];

  // one root bit per stage, radicand consumed two bits at a time from the top
  for (genvar g = 0; g < vn_pkg::SqrtStages; g++) begin : g_stage
    logic [31:0]      rad_in;
    vn_pkg::sqrt_st_t st_in;

    if (g == 0) begin : g_first
      assign rad_in = rad_i;
      assign st_in  = '0;
    end else begin : g_next
      assign rad_in = rad_q[g-1];
      assign st_in  = st_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      rad_q[g] <= {rad_in[29:0], 2'b00};
      st_q[g]  <= vn_pkg::sqrt_step(st_in.rem, st_in.root, rad_in[31:30]);
    end
  end

  assign root_o = st_q[vn_pkg::SqrtStages-1].root;

endmodule

// File: rtl/vector3_normalize_top.sv
// Vector normalizer: each request (vec_x, vec_y, vec_z) returns the vector
// scaled to unit length in signed Q2.14 (16384 = 1.0, rounded toward zero) and
// the truncated Euclidean length. An all-zero vector gives zero outputs with
// zero_vector set. A request is taken in every cycle (busy stays low) and its
// result is held on result_o for one cycle with done_o; it passes through
// three front registers (input, squares, sum of squares), 29 stages of a
// bit-per-stage divider and 16 stages of a bit-per-stage square root, then
// the output register. Results come out in request order and cannot be held.
module vector3_normalize_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  vn_pkg::in_t  req_i,
  output logic         done_o,
  output vn_pkg::out_t result_o
);

  logic              vld0_q, vld1_q, vld2_q;
  vn_pkg::in_t       in_q;
  logic [2:0][30:0]  sq_q;
  logic [2:0][30:0]  sq2_q;
  logic [31:0]       sum_q;
  vn_pkg::side_t     side1_q, side2_q;
  logic [2:0][30:0]  sq_d;

  logic              div_vld;
  logic [2:0][28:0]  quo;
  vn_pkg::side_t     div_side;
  logic [15:0]       len_root;
  logic [2:0][15:0]  unit_root;

  logic [vn_pkg::SqrtStages-1:0] dly_vld_q;
  vn_pkg::side_t                 dly_side_q [vn_pkg::SqrtStages];

  logic         done_q;
  vn_pkg::out_t result_q;
  vn_pkg::out_t result_d;

  assign busy = 1'b0;

  // magnitudes and squares
  always_comb begin
    logic [16:0] mag;
    for (int l = 0; l < 3; l++) begin
      mag     = 17'(in_q[47-16*l -: 16]);
      mag     = in_q[47-16*l] ? 17'(17'h10000 - {1'b0, in_q[47-16*l -: 16]}) :
                {1'b0, in_q[47-16*l -: 16]};
      sq_d[2-l] = 31'(34'(mag) * 34'(mag));
    end
  end

  // front registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q         <= req_i;
    sq_q         <= sq_d;
    side1_q.neg  <= {in_q.vec_x[15], in_q.vec_y[15], in_q.vec_z[15]};
    side1_q.zero <= (in_q.vec_x == '0) && (in_q.vec_y == '0) && (in_q.vec_z == '0);
    sq2_q        <= sq_q;
    sum_q        <= 32'({1'b0, sq_q[0]}) + 32'({1'b0, sq_q[1]}) + 32'({1'b0, sq_q[2]});
    side2_q      <= side1_q;
  end

  // sq index 2 is x, 1 is y, 0 is z
  vn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld2_q),
    .sum_i   (sum_q),
    .sq_i    (sq2_q),
    .side_i  (side2_q),
    .valid_o (div_vld),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  // square root of the sum, delayed alongside the divider
  logic [31:0] sum_dly_q [vn_pkg::DivStages];
  for (genvar g = 0; g < vn_pkg::DivStages; g++) begin : g_sum_dly
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) sum_dly_q[g] <= sum_q;
    end else begin : g_next
      always_ff @(posedge clk_i) sum_dly_q[g] <= sum_dly_q[g-1];
    end
  end

  vn_sqrt u_sqrt_len (
    .clk_i  (clk_i),
    .rad_i  (sum_dly_q[vn_pkg::DivStages-1]),
    .root_o (len_root)
  );

  for (genvar l = 0; l < 3; l++) begin : g_unit
    vn_sqrt u_sqrt_unit (
      .clk_i  (clk_i),
      .rad_i  ({3'b000, quo[l]}),
      .root_o (unit_root[l])
    );
  end

  // sideband delay across the square root
  for (genvar g = 0; g < vn_pkg::SqrtStages; g++) begin : g_side_dly
    logic          v_in;
    vn_pkg::side_t s_in;
    if (g == 0) begin : g_first
      assign v_in = div_vld;
      assign s_in = div_side;
    end else begin : g_next
      assign v_in = dly_vld_q[g-1];
      assign s_in = dly_side_q[g-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dly_vld_q[g] <= 1'b0;
      end else begin
        dly_vld_q[g] <= v_in;
      end
    end
    always_ff @(posedge clk_i) dly_side_q[g] <= s_in;
  end

  // sign and zero vector fixup
  always_comb begin
    vn_pkg::side_t s;
    s = dly_side_q[vn_pkg::SqrtStages-1];
    result_d.unit_x = s.neg[2] ? 16'(16'h0 - unit_root[2]) : unit_root[2];
    result_d.unit_y = s.neg[1] ? 16'(16'h0 - unit_root[1]) : unit_root[1];
    result_d.unit_z = s.neg[0] ? 16'(16'h0 - unit_root[0]) : unit_root[0];
    result_d.length = len_root;
    result_d.zero_vector = s.zero;
    if (s.zero) begin
      result_d = '0;
      result_d.zero_vector = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dly_vld_q[vn_pkg::SqrtStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // each result traces back to a request taken at the pipeline latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, vn_pkg::Latency))
    else $error("result without matching request");

  // a zero vector gives all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.zero_vector |-> result_o.length == '0 &&
      result_o.unit_x == '0 && result_o.unit_y == '0 && result_o.unit_z == '0)
    else $error("zero vector with nonzero fields");

  // a nonzero vector has nonzero length and a bounded x component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.zero_vector |-> result_o.length != '0 &&
      result_o.unit_x <= 16'sd16384 && result_o.unit_x >= -16'sd16384)
    else $error("nonzero vector result out of range");

  // the input register captures the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_q == $past(req_i))
    else $error("input register did not capture request");

endmodule

// File: bench/vector3_normalize_checker.sv
module vector3_normalize_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         busy,
  input  vn_pkg::in_t  req_i,
  input  logic         done_o,
  input  vn_pkg::out_t result_o,
  output int           err_cnt_o,
  output int           pending_o
);

  vn_pkg::out_t norm_q[$];
  int           err_cnt_q = 0;

  // floor of the square root of a 64-bit value, digit by digit
  function automatic logic [63:0] int_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [15:0] c);
    logic [63:0] m;
    m = c[15] ? 64'(17'h10000 - {1'b0, c}) : 64'(c);
    return m;
  endfunction

  // unit component in Q2.14, rounded toward zero
  function automatic logic [15:0] unit_of(input logic signed [15:0] c,
                                          input logic [63:0] sumsq);
    logic [63:0] m;
    logic [63:0] q;
    m = magnitude(c);
    q = int_root(((m * m) << 28) / sumsq);
    return c[15] ? 16'(-q) : q[15:0];
  endfunction

  function automatic vn_pkg::out_t normalize(input vn_pkg::in_t v);
    vn_pkg::out_t r;
    logic [63:0]  s;
    logic [63:0]  len;
    s = magnitude(v.vec_x) ** 2 + magnitude(v.vec_y) ** 2 + magnitude(v.vec_z) ** 2;
    r = '0;
    if (s == 0) begin
      r.zero_vector = 1'b1;
    end else begin
      r.unit_x = unit_of(v.vec_x, s);
      r.unit_y = unit_of(v.vec_y, s);
      r.unit_z = unit_of(v.vec_z, s);
      len      = int_root(s);
      r.length = len[15:0];
    end
    return r;
  endfunction

  assign pending_o = norm_q.size();
  assign err_cnt_o = err_cnt_q;

  // predict on each request, compare each result
  always @(posedge clk_i) begin
    vn_pkg::out_t exp_r;
    if (rst_ni) begin
      if (start && !busy) norm_q.push_back(normalize(req_i));
      if (done_o) begin
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_o);
          err_cnt_q <= err_cnt_q + 1;
        end else begin
          exp_r = norm_q.pop_front();
          if (exp_r !== result_o) begin
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d len=%0d zero=%0b",
                     $time, exp_r.unit_x, exp_r.unit_y, exp_r.unit_z,
                     exp_r.length, exp_r.zero_vector);
            $display("%0t:          got x=%0d y=%0d z=%0d len=%0d zero=%0b",
                     $time, result_o.unit_x, result_o.unit_y, result_o.unit_z,
                     result_o.length, result_o.zero_vector);
            err_cnt_q <= err_cnt_q + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_vector3_normalize_top.sv
module tb_vector3_normalize_top;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  vn_pkg::in_t  req_i = '0;
  logic         done_o;
  vn_pkg::out_t result_o;
  int           err_cnt;
  int           pending;

  vector3_normalize_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .result_o(result_o)
  );

  vector3_normalize_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .result_o(result_o), .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random component, biased toward the extremes and small values
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_vec(input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] z);
    start <= 1'b1;
    req_i <= '{vec_x: x, vec_y: y, vec_z: z};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    int n_sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero, axes, extremes, mixed signs
    send_vec(16'h0000, 16'h0000, 16'h0000);
    send_vec(16'h8000, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h7fff, 16'h0000);
    send_vec(16'h0000, 16'h0000, 16'hffff);
    send_vec(16'h0001, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h0000, 16'h8000);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff);
    send_vec(16'h8000, 16'h7fff, 16'h8000);
    send_vec(16'h0001, 16'h0001, 16'h0001);
    send_vec(16'hffff, 16'h0001, 16'hffff);
    send_vec(16'h5555, 16'haaaa, 16'h0000);
    send_vec(16'haaaa, 16'h5555, 16'hffff);
    send_vec(16'h0003, 16'h0004, 16'h0000);
    send_vec(16'hfffd, 16'h0000, 16'hfffc);
    idle_gap(3);
    // random: bursts with random gaps
    n_sent = 0;
    while (n_sent < 1550) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_vec(rand_comp(), rand_comp(), rand_comp());
        n_sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (vn_pkg::Latency + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
rtl/vn_pkg.sv
rtl/vn_div.sv
rtl/vn_sqrt.sv
rtl/vector3_normalize_top.sv
bench/vector3_normalize_checker.sv
bench/tb_vector3_normalize_top.sv
